>>> design/scl_pkg.sv
// Shared constants and types for the shuffled combined LCG generator.
// Used by every module of the block; depends on nothing else.
package scl_pkg;

  localparam int VAL_W = 31;

  // First generator: x <- 40014 * x mod (2^31 - 85).
  localparam logic [31:0] MOD1  = 32'd2147483563;
  localparam logic [15:0] MUL1  = 16'd40014;
  localparam logic [7:0]  FOLD1 = 8'd85;

  // Second generator: y <- 40692 * y mod (2^31 - 249).
  localparam logic [31:0] MOD2  = 32'd2147483399;
  localparam logic [15:0] MUL2  = 16'd40692;
  localparam logic [7:0]  FOLD2 = 8'd249;

  localparam logic [VAL_W-1:0] SEED2_RESET = 31'd123456789;
  localparam logic [31:0]      MOD1_LESS1  = 32'd2147483562;

  // raw * 2^32 / MOD1 = 2 * raw + raw * 170 / MOD1, since 2^32 = 2 * MOD1 + 170.
  localparam logic [7:0]  FRAC_FOLD = 8'd170;
  localparam logic [31:0] FRAC_MAX  = 32'd4294966780;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WARM_WAIT,
    ST_WARM_STEP,
    ST_SEED_SLOT,
    ST_DRAW_ISSUE,
    ST_DRAW_WAIT,
    ST_DRAW_COMB,
    ST_DRAW_POST,
    ST_DRAW_HOLD
  } scl_state_t;

endpackage

>>> design/scl_lcg_step.sv
// Two-lane modular multiply pipeline that advances both generators by one step.
// Depends on scl_pkg for the multipliers and moduli.
module scl_lcg_step
  import scl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [VAL_W-1:0] x_in,
  input  logic [VAL_W-1:0] y_in,
  output logic             done,
  output logic [VAL_W-1:0] x_out,
  output logic [VAL_W-1:0] y_out
);

  logic [46:0]      px_r, py_r;
  logic             v1_r, v2_r;
  logic [VAL_W-1:0] x_r, y_r;
  logic [31:0]      sx, sy;

  // The modulus is 2^31 - k, so the high part folds back in as hi * k.
  // The folded sum stays below twice the modulus.
  always_comb begin
    sx = {1'b0, px_r[30:0]} + 32'(px_r[46:31]) * 32'(FOLD1);
    sy = {1'b0, py_r[30:0]} + 32'(py_r[46:31]) * 32'(FOLD2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      px_r <= 47'(x_in) * 47'(MUL1);
      py_r <= 47'(y_in) * 47'(MUL2);
    end
    if (v1_r) begin
      x_r <= (sx >= MOD1) ? VAL_W'(sx - MOD1) : VAL_W'(sx);
      y_r <= (sy >= MOD2) ? VAL_W'(sy - MOD2) : VAL_W'(sy);
    end
  end

  assign done  = v2_r;
  assign x_out = x_r;
  assign y_out = y_r;

endmodule

>>> design/scl_table.sv
// Shuffle table memory: one write port, one registered read port.
// Entries never written since reset read as zero. Depends on scl_pkg.
module scl_table
  import scl_pkg::*;
#(
  parameter int TABLE_DEPTH = 32,
  parameter int IDXW        = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [IDXW-1:0]  rd_addr,
  output logic [VAL_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [IDXW-1:0]  wr_addr,
  input  logic [VAL_W-1:0] wr_data
);

  logic [VAL_W-1:0]       mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld_r;
  logic [VAL_W-1:0]       rd_data_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

>>> design/scl_post.sv
// Output post-processing: Q0.32 fraction of a generator output and the
// shuffle slot it selects. Three-stage pipeline; depends on scl_pkg.
module scl_post
  import scl_pkg::*;
#(
  parameter int TABLE_DEPTH = 32,
  parameter int IDXW        = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [VAL_W-1:0] value,
  output logic             done,
  output logic [31:0]      frac,
  output logic [IDXW-1:0]  slot
);

  localparam int MW = IDXW + 2;
  localparam logic [VAL_W-1:0] SLOT_DIV = VAL_W'(32'd1 + (MOD1 - 32'd1) / 32'(TABLE_DEPTH));
  // Floor reciprocal: the quotient estimate is exact or one short.
  localparam logic [MW-1:0] SLOT_RECIP = MW'((64'd1 << 31) / 64'(SLOT_DIV));

  logic             vld0_r, vld1_r, vld2_r;
  logic [VAL_W-1:0] v0_r, v1_r;
  logic [38:0]      t_r;
  logic [MW-1:0]    q_est_r;
  logic [31:0]      frac_r;
  logic [IDXW-1:0]  slot_r;

  logic [VAL_W+MW-1:0] recip_prod;
  logic [7:0]          q0;
  logic [31:0]         rem;
  logic [31:0]         frac_raw;
  logic [MW-1:0]       q_inc;
  logic [MW+30:0]      bound;
  logic [MW-1:0]       q_fix;

  always_comb begin
    recip_prod = (VAL_W + MW)'(v0_r) * (VAL_W + MW)'(SLOT_RECIP);
    // Divide raw * 170 by MOD1 with the same fold as the generator step.
    q0       = t_r[38:31];
    rem      = {1'b0, t_r[30:0]} + 32'(q0) * 32'(FOLD1);
    frac_raw = {v1_r, 1'b0} + 32'(q0) + ((rem >= MOD1) ? 32'd1 : 32'd0);
    q_inc    = q_est_r + MW'(1);
    bound    = (MW + 31)'(q_inc) * (MW + 31)'(SLOT_DIV);
    q_fix    = ((MW + 31)'(v1_r) >= bound) ? q_inc : q_est_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld0_r <= start;
      vld1_r <= vld0_r;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v0_r <= value;
    end
    if (vld0_r) begin
      v1_r    <= v0_r;
      t_r     <= 39'(v0_r) * 39'(FRAC_FOLD);
      q_est_r <= recip_prod[VAL_W+MW-1:VAL_W];
    end
    if (vld1_r) begin
      frac_r <= (frac_raw > FRAC_MAX) ? FRAC_MAX : frac_raw;
      slot_r <= (q_fix >= MW'(TABLE_DEPTH)) ? IDXW'(TABLE_DEPTH - 1) : q_fix[IDXW-1:0];
    end
  end

  assign done = vld2_r;
  assign frac = frac_r;
  assign slot = slot_r;

endmodule

>>> design/shuffled_combined_lcg_generator.sv
// Shuffled combined LCG random source (top level; uses scl_pkg, scl_lcg_step,
// scl_table and scl_post). Two multiplicative congruential generators, one
// modulo 2147483563 and one modulo 2147483399, are combined through a shuffle
// table of TABLE_DEPTH entries held in a synchronous RAM. Every input transfer
// yields exactly one output transfer. A transfer with in_tuser set reseeds:
// both generators load the seed in in_tdata (zero counts as one), then
// TABLE_DEPTH + WARMUP_EXTRA warm-up steps run, the last TABLE_DEPTH of them
// filling the table, and a draw follows. A transfer with in_tuser clear just
// draws. The output carries the raw integer and its Q0.32 fraction of the
// first modulus, saturated just below one. One item is in work at a time.
// A plain draw passes through the modular multiply pipeline and table read,
// then a combine step that writes back the table, then the fraction and
// slot pipeline. A reseed adds the warm-up steps, which run one after another
// because each warm-up step waits for the previous one to leave the multiply
// pipeline. The output register lets a new input transfer be taken while the
// previous result still waits for out_tready.
module shuffled_combined_lcg_generator
  import scl_pkg::*;
#(
  parameter int TABLE_DEPTH  = 32,
  parameter int WARMUP_EXTRA = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [30:0] seed, [31] zero
  input  logic [0:0]  in_tuser,   // [0] action: 1 = reseed then draw
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // [30:0] raw_value, [62:31] fraction, [63] zero
);

  localparam int IDXW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int TOTAL = TABLE_DEPTH + WARMUP_EXTRA;
  localparam int CNTW  = $clog2(TOTAL);

  scl_state_t state_r, state_nxt;

  logic [VAL_W-1:0] first_gen_r, first_gen_nxt;
  logic [VAL_W-1:0] second_gen_r, second_gen_nxt;
  logic [VAL_W-1:0] last_output_r, last_output_nxt;
  logic [IDXW-1:0]  slot_r, slot_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_raw_r, out_raw_nxt;
  logic [31:0]      out_frac_r, out_frac_nxt;

  logic             in_accept;
  logic             out_free;
  logic [VAL_W-1:0] seed_fix;

  logic             step_start, step_done;
  logic [VAL_W-1:0] step_x, step_y, step_x_out, step_y_out;

  logic             tbl_rd_en, tbl_wr_en;
  logic [IDXW-1:0]  tbl_wr_addr;
  logic [VAL_W-1:0] tbl_wr_data, tbl_rd_data;

  logic             post_start, post_done;
  logic [VAL_W-1:0] post_value;
  logic [31:0]      post_frac;
  logic [IDXW-1:0]  post_slot;

  logic [31:0]      diff;
  logic [VAL_W-1:0] comb_val;

  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign seed_fix  = (in_tdata[VAL_W-1:0] == '0) ? VAL_W'(1) : in_tdata[VAL_W-1:0];

  // Combination of the picked table entry with the new second generator value;
  // a result that is not positive wraps by MOD1 - 1.
  always_comb begin
    diff     = {1'b0, tbl_rd_data} - {1'b0, step_y_out};
    comb_val = (tbl_rd_data <= step_y_out) ? VAL_W'(diff + MOD1_LESS1) : VAL_W'(diff);
  end

  scl_lcg_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .start (step_start),
    .x_in  (step_x),
    .y_in  (step_y),
    .done  (step_done),
    .x_out (step_x_out),
    .y_out (step_y_out)
  );

  scl_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDXW        (IDXW)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (tbl_rd_en),
    .rd_addr (slot_r),
    .rd_data (tbl_rd_data),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data)
  );

  scl_post #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDXW        (IDXW)
  ) u_post (
    .clk   (clk),
    .rst_n (rst_n),
    .start (post_start),
    .value (post_value),
    .done  (post_done),
    .frac  (post_frac),
    .slot  (post_slot)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = in_tuser[0] ? ST_WARM_WAIT : ST_DRAW_WAIT;
        end
      end
      ST_WARM_WAIT: begin
        state_nxt = ST_WARM_STEP;
      end
      ST_WARM_STEP: begin
        state_nxt = (cnt_r == '0) ? ST_SEED_SLOT : ST_WARM_WAIT;
      end
      ST_SEED_SLOT: begin
        if (post_done) begin
          state_nxt = ST_DRAW_ISSUE;
        end
      end
      ST_DRAW_ISSUE: begin
        state_nxt = ST_DRAW_WAIT;
      end
      ST_DRAW_WAIT: begin
        state_nxt = ST_DRAW_COMB;
      end
      ST_DRAW_COMB: begin
        state_nxt = ST_DRAW_POST;
      end
      ST_DRAW_POST: begin
        if (post_done) begin
          state_nxt = out_free ? ST_IDLE : ST_DRAW_HOLD;
        end
      end
      ST_DRAW_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath control and register updates.
  always_comb begin
    in_tready       = 1'b0;
    step_start      = 1'b0;
    step_x          = first_gen_r;
    step_y          = second_gen_r;
    tbl_rd_en       = 1'b0;
    tbl_wr_en       = 1'b0;
    tbl_wr_addr     = slot_r;
    tbl_wr_data     = step_x_out;
    post_start      = 1'b0;
    post_value      = comb_val;
    first_gen_nxt   = first_gen_r;
    second_gen_nxt  = second_gen_r;
    last_output_nxt = last_output_r;
    slot_nxt        = slot_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_raw_nxt     = out_raw_r;
    out_frac_nxt    = out_frac_r;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_accept) begin
          step_start = 1'b1;
          if (in_tuser[0]) begin
            step_x         = seed_fix;
            step_y         = seed_fix;
            first_gen_nxt  = seed_fix;
            second_gen_nxt = seed_fix;
            cnt_nxt        = CNTW'(TOTAL - 1);
          end else begin
            tbl_rd_en = 1'b1;
          end
        end
      end
      ST_WARM_STEP: begin
        first_gen_nxt = step_x_out;
        tbl_wr_en     = (cnt_r < CNTW'(TABLE_DEPTH));
        tbl_wr_addr   = cnt_r[IDXW-1:0];
        if (cnt_r == '0) begin
          // The last warm-up value fills slot zero and is the previous output.
          last_output_nxt = step_x_out;
          post_start      = 1'b1;
          post_value      = step_x_out;
        end else begin
          step_start = 1'b1;
          step_x     = step_x_out;
          cnt_nxt    = cnt_r - CNTW'(1);
        end
      end
      ST_SEED_SLOT: begin
        if (post_done) begin
          slot_nxt = post_slot;
        end
      end
      ST_DRAW_ISSUE: begin
        step_start = 1'b1;
        tbl_rd_en  = 1'b1;
      end
      ST_DRAW_COMB: begin
        first_gen_nxt   = step_x_out;
        second_gen_nxt  = step_y_out;
        tbl_wr_en       = 1'b1;
        last_output_nxt = comb_val;
        post_start      = 1'b1;
      end
      ST_DRAW_POST: begin
        if (post_done) begin
          slot_nxt = post_slot;
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_raw_nxt   = last_output_r;
            out_frac_nxt  = post_frac;
          end
        end
      end
      ST_DRAW_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_raw_nxt   = last_output_r;
          out_frac_nxt  = post_frac;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      first_gen_r   <= '0;
      second_gen_r  <= SEED2_RESET;
      last_output_r <= '0;
      slot_r        <= '0;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      first_gen_r   <= first_gen_nxt;
      second_gen_r  <= second_gen_nxt;
      last_output_r <= last_output_nxt;
      slot_r        <= slot_nxt;
      cnt_r         <= cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_raw_r  <= out_raw_nxt;
    out_frac_r <= out_frac_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_frac_r, out_raw_r};

  // The previous output always lies inside the first modulus.
  a_last_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, last_output_r} < MOD1)
    else $error("previous output outside the first modulus");

  // The slot register never points past the table.
  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= IDXW'(TABLE_DEPTH - 1))
    else $error("shuffle slot beyond table depth");

  // Step results arrive only where the sequencer consumes them.
  a_step_timing: assert property (@(posedge clk) disable iff (!rst_n)
    step_done |-> (state_r == ST_WARM_STEP || state_r == ST_DRAW_COMB))
    else $error("generator step result arrived in an unexpected state");

  // Post results arrive only while the sequencer waits for them.
  a_post_timing: assert property (@(posedge clk) disable iff (!rst_n)
    post_done |-> (state_r == ST_SEED_SLOT || state_r == ST_DRAW_POST))
    else $error("fraction and slot result arrived in an unexpected state");

  // A new result is only presented after the post pipeline finished a draw.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(post_done) || $past(state_r == ST_DRAW_HOLD)))
    else $error("output presented without a finished draw");

endmodule

>>> sim/scl_checker.sv
`timescale 1ns / 100ps
// Checker for the shuffled combined LCG generator: watches both streams, keeps
// its own model of the two generators and the shuffle table, compares results.
// Depends on scl_pkg for widths and generator constants.
module scl_checker
  import scl_pkg::*;
#(
  parameter int TABLE_DEPTH  = 32,
  parameter int WARMUP_EXTRA = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // [30:0] seed, [31] zero
  input  logic [0:0]  in_tuser,   // [0] action: 1 = reseed then draw
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,  // [30:0] raw_value, [62:31] fraction, [63] zero
  output int          fail_count,
  output int          pending
);

  localparam longint unsigned SLOT_SPAN = 1 + (64'(MOD1) - 1) / TABLE_DEPTH;

  typedef struct packed {
    logic [VAL_W-1:0] raw;
    logic [31:0]      frac;
  } draw_t;

  logic [VAL_W-1:0] gen_a;
  logic [VAL_W-1:0] gen_b;
  logic [VAL_W-1:0] prev_raw;
  logic [VAL_W-1:0] shuffle [TABLE_DEPTH];
  draw_t            draws_due [$];

  function automatic logic [VAL_W-1:0] mcg_step(logic [VAL_W-1:0] x, logic [15:0] mul,
                                                logic [31:0] modulus);
    longint unsigned prod;
    prod = 64'(x) * 64'(mul);
    return VAL_W'(prod % 64'(modulus));
  endfunction

  // Advances the model by one input transfer and returns the draw it yields.
  function automatic draw_t predict_draw(logic reseed, logic [VAL_W-1:0] seed);
    longint unsigned slot;
    longint unsigned q;
    longint          mix;
    draw_t           d;
    if (reseed) begin
      gen_a = (seed == '0) ? VAL_W'(1) : seed;
      gen_b = gen_a;
      // The last TABLE_DEPTH warm-up steps fill the table from the top down.
      for (int w = TABLE_DEPTH + WARMUP_EXTRA - 1; w >= 0; w--) begin
        gen_a = mcg_step(gen_a, MUL1, MOD1);
        if (w < TABLE_DEPTH) shuffle[w] = gen_a;
      end
      prev_raw = shuffle[0];
    end
    gen_a = mcg_step(gen_a, MUL1, MOD1);
    gen_b = mcg_step(gen_b, MUL2, MOD2);
    slot = 64'(prev_raw) / SLOT_SPAN;
    if (slot >= TABLE_DEPTH) slot = TABLE_DEPTH - 1;
    mix = longint'({33'd0, shuffle[slot]}) - longint'({33'd0, gen_b});
    shuffle[slot] = gen_a;
    if (mix < 1) mix = mix + longint'({32'd0, MOD1_LESS1});
    prev_raw = mix[VAL_W-1:0];
    q = {1'b0, prev_raw, 32'd0} / 64'(MOD1);
    if (q > 64'(FRAC_MAX)) q = 64'(FRAC_MAX);
    d.raw  = prev_raw;
    d.frac = q[31:0];
    return d;
  endfunction

  always @(posedge clk) begin : watch
    draw_t due;
    int    bad;
    bad = 0;
    if (!rst_n) begin
      gen_a    = '0;
      gen_b    = SEED2_RESET;
      prev_raw = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) shuffle[i] = '0;
      draws_due.delete();
      fail_count <= 0;
    end else begin
      // A result always belongs to an earlier input, so compare before predicting.
      if (out_tvalid && out_tready) begin
        if (draws_due.size() == 0) begin
          $display("%0t: out transfer with nothing expected, expected none, actual %h",
                   $time, out_tdata);
          bad = 1;
        end else begin
          due = draws_due.pop_front();
          if (out_tdata[30:0] !== due.raw) begin
            $display("%0t: raw_value mismatch, expected %0d, actual %0d",
                     $time, due.raw, out_tdata[30:0]);
            bad = 1;
          end
          if (out_tdata[62:31] !== due.frac) begin
            $display("%0t: fraction mismatch, expected %0d, actual %0d",
                     $time, due.frac, out_tdata[62:31]);
            bad = 1;
          end
          if (out_tdata[63] !== 1'b0) begin
            $display("%0t: pad bit mismatch, expected 0, actual %b", $time, out_tdata[63]);
            bad = 1;
          end
        end
      end
      if (in_tvalid && in_tready)
        draws_due.push_back(predict_draw(in_tuser[0], in_tdata[VAL_W-1:0]));
      fail_count <= fail_count + bad;
    end
    pending <= draws_due.size();
  end

endmodule

>>> sim/tb_shuffled_combined_lcg_generator.sv
`timescale 1ns / 100ps
// Testbench top for the shuffled combined LCG generator: drives seed and draw
// transfers, applies output backpressure and gives the verdict.
// Depends on scl_pkg, the generator RTL and scl_checker.
module tb_shuffled_combined_lcg_generator;
  import scl_pkg::*;

  localparam int TABLE_DEPTH  = 32;
  localparam int WARMUP_EXTRA = 8;

  // Action codes carried on in_tuser.
  localparam logic ACT_DRAW   = 1'b0;
  localparam logic ACT_RESEED = 1'b1;

  // Random transfers after the directed part, spread over three idling phases.
  localparam int RANDOM_ITEMS = 850;

  // A reseed is the longest transfer; even if every transfer were a reseed under
  // the heaviest idling, the run stays well under this.
  localparam int CYCLE_LIMIT = 500000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;

  int fail_count;
  int pending;
  int cycles = 0;
  int send_idle_pct;
  int recv_idle_pct;

  shuffled_combined_lcg_generator #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .WARMUP_EXTRA(WARMUP_EXTRA)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // The checker sees exactly what the block sees and keeps the expected draws.
  scl_checker #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .WARMUP_EXTRA(WARMUP_EXTRA)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result backpressure: each cycle the receiver stalls with the current odds.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog. A hang anywhere in the run ends here as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** shuffled_combined_lcg_generator: FAILED **");
      $finish;
    end
  end

  // Offers one transfer after a random number of idle cycles and returns at the
  // edge that accepts it. in_tvalid stays high so that back-to-back transfers
  // need no second assignment in the same step.
  task automatic send_item(input logic act, input logic [VAL_W-1:0] seed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, seed};
    in_tuser  <= act;
    do @(posedge clk); while (!in_tready);
  endtask

  // Holds the input off until every predicted result has come out. The first
  // edge is always awaited so that the checker has counted the last transfer.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Seeds lean toward the special ranges: zero, tiny values, and values just below,
  // at or above the moduli, which the block must reduce exactly.
  function automatic logic [VAL_W-1:0] pick_seed();
    case ($urandom_range(15))
      0:       return '0;
      1:       return VAL_W'($urandom_range(32'h7FFF_FFFF, MOD2 - 32'd4));
      2:       return VAL_W'($urandom_range(8));
      default: return VAL_W'($urandom);
    endcase
  endfunction

  initial begin
    int sent;
    int run_len;
    int kind;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= ACT_DRAW;
    rst_n      <= 1'b0;
    send_idle_pct = 34;
    recv_idle_pct = 62;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Draws before any reseed run from the reset state with an all-zero table.
    // The seed field must be ignored on a draw, so it carries odd patterns here.
    send_item(ACT_DRAW, '0);
    send_item(ACT_DRAW, '1);
    send_item(ACT_DRAW, 31'h2AAA_AAAA);

    // Zero seed is taken as one, so these two sequences must match.
    send_item(ACT_RESEED, '0);
    send_item(ACT_DRAW, '0);
    send_item(ACT_RESEED, 31'd1);
    send_item(ACT_DRAW, '1);

    // Seeds just below, at and beyond both moduli, and the largest seed the field holds.
    send_item(ACT_RESEED, '1);
    send_item(ACT_DRAW, '0);
    send_item(ACT_RESEED, VAL_W'(MOD1));
    send_item(ACT_DRAW, '0);
    send_item(ACT_RESEED, VAL_W'(MOD1 - 32'd1));
    send_item(ACT_RESEED, VAL_W'(MOD2));
    send_item(ACT_DRAW, '0);
    send_item(ACT_RESEED, VAL_W'(MOD2 - 32'd1));

    // Alternating bit patterns, then a few plain draws to work the shuffle.
    send_item(ACT_RESEED, 31'h5555_5555);
    send_item(ACT_DRAW, 31'h5555_5555);
    send_item(ACT_RESEED, 31'h2AAA_AAAA);
    for (int i = 0; i < 5; i++) send_item(ACT_DRAW, VAL_W'($urandom));

    // Let everything settle before the random part starts.
    drain();

    // Random part in three idling phases. Most traffic is a reseed followed by
    // a run of draws; the rest is bare draw runs and reseeds that are
    // not followed by a draw run of their own.
    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 34;
          recv_idle_pct = 62;
        end
        1: begin
          send_idle_pct = 62;
          recv_idle_pct = 34;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      while (sent < (phase + 1) * RANDOM_ITEMS / 3) begin
        kind = $urandom_range(9);
        if (kind == 0) begin
          run_len = $urandom_range(1, 12);
        end else if (kind == 1) begin
          send_item(ACT_RESEED, pick_seed());
          sent++;
          run_len = 0;
        end else begin
          send_item(ACT_RESEED, pick_seed());
          sent++;
          run_len = $urandom_range(1, 24);
        end
        for (int i = 0; i < run_len; i++) send_item(ACT_DRAW, VAL_W'($urandom));
        sent += run_len;
      end
      // The sender waits here for every outstanding result before going on.
      drain();
    end

    // Give the block time to show any extra output.
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** shuffled_combined_lcg_generator: PASSED **");
    end else begin
      $display("** shuffled_combined_lcg_generator: FAILED **");
    end
    $finish;
  end

endmodule
